// ===== hdl/rosc_pkg.sv =====
// shared constants, codes and control types of the rolling offset substitution cipher
package rosc_pkg;

   // default symbol count of the printable set
   localparam int SYMBOLS_DEF = 95;

   // code of the first printable symbol (space)
   localparam logic [7:0] FIRST_CODE = 8'd32;

   localparam int CHAR_W     = 8;
   localparam int FIELD_W    = 7;
   localparam int PASS_W     = 8;
   localparam int REQ_TYPE_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ENCRYPT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DECRYPT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSES       = 2'd2;

   // register reset values
   localparam logic [FIELD_W-1:0] START_OFFSET_RESET = 7'd0;
   localparam logic [FIELD_W-1:0] OFFSET_STEP_RESET  = 7'd2;
   localparam logic [PASS_W-1:0]  PASSES_RESET       = 8'd99;

   // controller to datapath
   typedef struct packed {
      logic start;     // latch a character and its offset
      logic decrypt;   // latched character is a decrypt
      logic wr_table;  // write a table entry pair
      logic step;      // issue one table lookup
      logic load_out;  // capture the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // no lookups left for this character
      logic oor;         // latched character is outside the symbol range
   } status_type;

endpackage

// ===== hdl/rosc_ctrl.sv =====
// controller state machine: request sequencing and output register handshake
module rosc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rosc_pkg::REQ_TYPE_W-1:0]     req_kind,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output rosc_pkg::cmd_type                   cmd,
   input  rosc_pkg::status_type                sts
);

   typedef enum logic [0:0] {
      IDLE,
      RUN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;
   logic      cipher_req;

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cipher_req = (req_kind == rosc_pkg::REQ_ENCRYPT) ||
                       (req_kind == rosc_pkg::REQ_DECRYPT);

   always_comb begin
      cmd.start    = accept && cipher_req;
      cmd.decrypt  = (req_kind == rosc_pkg::REQ_DECRYPT);
      cmd.wr_table = accept && (req_kind == rosc_pkg::REQ_LOAD);
      cmd.step     = (state_ff == RUN) && !sts.count_zero && !sts.oor;
      cmd.load_out = (state_ff == RUN) && (sts.count_zero || sts.oor) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (cmd.start) begin
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (cmd.load_out) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result captured while output register busy");

   // no lookup once the pass count is spent
   a_no_extra_step: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!sts.count_zero && !sts.oor))
      else $error("lookup issued with no passes left");

   // a new result only follows a character being worked on
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == RUN))
      else $error("result appeared without a character in work");

   // a cipher request moves the controller into the lookup loop
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == RUN))
      else $error("cipher request did not start the lookup loop");
`endif

endmodule

// ===== hdl/rosc_dp.sv =====
// datapath: config registers, table memories, running offset and lookup loop
module rosc_dp #(
   parameter int SYMBOLS = rosc_pkg::SYMBOLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rosc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rosc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                first_of_message,
   input  logic [rosc_pkg::CHAR_W-1:0]         char_in,
   input  logic [rosc_pkg::FIELD_W-1:0]        table_index,
   input  logic [rosc_pkg::FIELD_W-1:0]        table_value,
   input  rosc_pkg::cmd_type                   cmd,
   output rosc_pkg::status_type                sts,
   output logic [rosc_pkg::CHAR_W-1:0]         char_out,
   output logic                                out_of_range
);

   localparam int AW        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int CODE_LIM  = 32 + SYMBOLS;

   // x mod SYMBOLS for a 7-bit value, by shifted compare and subtract
   function automatic logic [AW-1:0] mod_sym(input logic [rosc_pkg::FIELD_W-1:0] x);
      logic [13:0] r;
      logic [13:0] m;
      r = 14'(x);
      for (int j = 6; j >= 0; j--) begin
         m = 14'(SYMBOLS) << j;
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[AW-1:0];
   endfunction

   // (a + b) mod SYMBOLS, both below SYMBOLS
   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW+1)'(SYMBOLS)) begin
         s = s - (AW+1)'(SYMBOLS);
      end
      return s[AW-1:0];
   endfunction

   // (t - k) mod SYMBOLS, both below SYMBOLS
   function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] t, input logic [AW-1:0] k);
      logic [AW:0] s;
      s = {1'b0, t} + ((AW+1)'(SYMBOLS) - {1'b0, k});
      if (s >= (AW+1)'(SYMBOLS)) begin
         s = s - (AW+1)'(SYMBOLS);
      end
      return s[AW-1:0];
   endfunction

   // table memories
   logic [AW-1:0] fwd_mem [SYMBOLS];
   logic [AW-1:0] rev_mem [SYMBOLS];

   // config; the two offsets are reduced mod SYMBOLS on write
   logic [AW-1:0]                  start_mod_ff;
   logic [AW-1:0]                  step_mod_ff;
   logic [rosc_pkg::PASS_W-1:0]    passes_ff;

   // per-character state
   logic [AW-1:0]                  run_off_ff;
   logic [AW-1:0]                  run_off_in;
   logic [AW-1:0]                  k_ff;
   logic [AW-1:0]                  k_in;
   logic [AW-1:0]                  sym_ff;
   logic                           pend_ff;
   logic [rosc_pkg::PASS_W-1:0]    cnt_ff;
   logic                           decrypt_ff;
   logic                           oor_ff;
   logic [rosc_pkg::CHAR_W-1:0]    char_ff;
   logic [AW-1:0]                  rd_fwd_ff;
   logic [AW-1:0]                  rd_rev_ff;
   logic [rosc_pkg::CHAR_W-1:0]    rsp_char_ff;
   logic [rosc_pkg::CHAR_W-1:0]    rsp_char_in;
   logic                           rsp_oor_ff;

   logic [AW-1:0]                  cur_sym;
   logic [AW-1:0]                  addr;
   logic                           in_range;
   logic                           load_ok;
   logic [rosc_pkg::CHAR_W-1:0]    char_sym;

   assign in_range = (char_in >= rosc_pkg::FIRST_CODE) &&
                     ({1'b0, char_in} < 9'(CODE_LIM));
   assign load_ok  = ({1'b0, table_index} < 8'(SYMBOLS)) &&
                     ({1'b0, table_value} < 8'(SYMBOLS));
   assign char_sym = char_in - rosc_pkg::FIRST_CODE;

   assign k_in       = first_of_message ? start_mod_ff : run_off_ff;
   assign run_off_in = add_mod(k_in, step_mod_ff);

   // symbol after the last issued lookup
   always_comb begin
      if (!pend_ff) begin
         cur_sym = sym_ff;
      end else if (decrypt_ff) begin
         cur_sym = sub_mod(rd_rev_ff, k_ff);
      end else begin
         cur_sym = rd_fwd_ff;
      end
      addr        = decrypt_ff ? cur_sym : add_mod(cur_sym, k_ff);
      rsp_char_in = oor_ff ? char_ff : (rosc_pkg::CHAR_W'(cur_sym) + rosc_pkg::FIRST_CODE);
   end

   assign sts.count_zero = (cnt_ff == '0);
   assign sts.oor        = oor_ff;
   assign char_out       = rsp_char_ff;
   assign out_of_range   = rsp_oor_ff;

   // config registers and running offset
   always_ff @(posedge clock) begin
      if (reset) begin
         start_mod_ff <= mod_sym(rosc_pkg::START_OFFSET_RESET);
         step_mod_ff  <= mod_sym(rosc_pkg::OFFSET_STEP_RESET);
         passes_ff    <= rosc_pkg::PASSES_RESET;
         run_off_ff   <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         oor_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rosc_pkg::CSR_START_OFFSET: start_mod_ff <= mod_sym(csr_wdata[6:0]);
               rosc_pkg::CSR_OFFSET_STEP:  step_mod_ff  <= mod_sym(csr_wdata[6:0]);
               rosc_pkg::CSR_PASSES:       passes_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.start) begin
            run_off_ff <= run_off_in;
            pend_ff    <= 1'b0;
            cnt_ff     <= passes_ff;
            oor_ff     <= !in_range;
         end else if (cmd.step) begin
            pend_ff <= 1'b1;
            cnt_ff  <= cnt_ff - 8'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         k_ff       <= k_in;
         sym_ff     <= char_sym[AW-1:0];
         decrypt_ff <= cmd.decrypt;
         char_ff    <= char_in;
      end else if (cmd.step) begin
         sym_ff <= cur_sym;
      end
      if (cmd.load_out) begin
         rsp_char_ff <= rsp_char_in;
         rsp_oor_ff  <= oor_ff;
      end
   end

   // table writes and registered lookups
   always_ff @(posedge clock) begin
      if (cmd.wr_table && load_ok) begin
         fwd_mem[table_index[AW-1:0]] <= table_value[AW-1:0];
         rev_mem[table_value[AW-1:0]] <= table_index[AW-1:0];
      end
      if (cmd.step) begin
         rd_fwd_ff <= fwd_mem[addr];
         rd_rev_ff <= rev_mem[addr];
      end
   end

endmodule

// ===== hdl/rolling_offset_substitution_cipher.sv =====
// top level of the rolling offset substitution cipher
//
//   channel   dir   handshake            payload
//   req_      in    req_tvalid/tready    tdata: message flag, char, table index, value
//                                        tuser: request kind
//   rsp_      out   rsp_tvalid/tready    tdata: char out; tuser: out of range flag
//   csr_      in    csr_we               csr_index, csr_wdata
//
// a table load is written when it is accepted; an encrypt or decrypt steps through accept,
// one table lookup per pass and capture, with no lookups when out of range;
// the lookups form a dependent chain through the single read port of each table
// reset is synchronous, loads the config registers with their reset values and clears the
// running offset and control; the tables hold garbage until loaded
// a finished result waits in the output register while the next transfer is taken
module rolling_offset_substitution_cipher #(
   parameter int SYMBOLS = rosc_pkg::SYMBOLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // first_of_message, char_in[7:0], table_index[6:0],
                                    // table_value[6:0], zero fill
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out[7:0]
   output logic        rsp_tuser,   // out_of_range
   // config write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   rosc_pkg::cmd_type    cmd;
   rosc_pkg::status_type sts;

   // unpacked request fields
   logic                               first_of_message;
   logic [rosc_pkg::CHAR_W-1:0]        char_in;
   logic [rosc_pkg::FIELD_W-1:0]       table_index;
   logic [rosc_pkg::FIELD_W-1:0]       table_value;

   assign first_of_message = req_tdata[0];
   assign char_in          = req_tdata[8:1];
   assign table_index      = req_tdata[15:9];
   assign table_value      = req_tdata[22:16];

   // sequencing and output valid
   rosc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // tables, offsets and the lookup loop
   rosc_dp #(
      .SYMBOLS (SYMBOLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .first_of_message (first_of_message),
      .char_in          (char_in),
      .table_index      (table_index),
      .table_value      (table_value),
      .cmd              (cmd),
      .sts              (sts),
      .char_out         (rsp_tdata),
      .out_of_range     (rsp_tuser)
   );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the rolling offset substitution cipher
`timescale 1ns / 100ps

module testbench;

   localparam int SYM           = rosc_pkg::SYMBOLS_DEF;
   localparam int SETTLE_CYCLES = 300;    // longest item: 255 passes plus accept and capture
   localparam int QUIET_LIMIT   = 5000;   // cycles without any transfer before giving up
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
   localparam int HOLD_AFTER    = 30;     // result transfers before the hold-off starts

   typedef logic [rosc_pkg::REQ_TYPE_W-1:0] kind_type;
   typedef logic [rosc_pkg::CHAR_W-1:0]     char_type;
   typedef logic [rosc_pkg::FIELD_W-1:0]    field_type;
   typedef logic [rosc_pkg::PASS_W-1:0]     pass_type;
   typedef logic [rosc_pkg::CSR_DATA_W-1:0] wdata_type;

   // request kind that the block drops
   localparam kind_type REQ_IGNORED = 2'd3;

   // edges of the printable range
   localparam char_type LAST_CODE = char_type'(int'(rosc_pkg::FIRST_CODE) + SYM - 1);
   localparam char_type PAST_CODE = char_type'(int'(rosc_pkg::FIRST_CODE) + SYM);

   // one request as the block sees it
   typedef struct packed {
      kind_type  kind;
      logic      msg_first;
      char_type  ch;
      field_type idx;
      field_type val;
   } cipher_req_type;

   // one result
   typedef struct packed {
      char_type ch;
      logic     oor;
   } cipher_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [23:0]                        req_tdata  = '0;
   logic [1:0]                         req_tuser  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [7:0]                         rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_we     = 1'b0;
   logic [rosc_pkg::CSR_IDX_W-1:0]     csr_index  = '0;
   wdata_type                          csr_wdata  = '0;

   rolling_offset_substitution_cipher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow state of the cipher: tables, running offset and registers
   field_type fwd_tab [SYM];
   field_type rev_tab [SYM];
   field_type run_off    = '0;
   field_type cfg_start  = rosc_pkg::START_OFFSET_RESET;
   field_type cfg_step   = rosc_pkg::OFFSET_STEP_RESET;
   pass_type  cfg_passes = rosc_pkg::PASSES_RESET;

   cipher_req_type pending_reqs [$];     // requests not yet offered
   cipher_rsp_type expected_chars [$];   // predicted results in order
   cipher_req_type cur_req;              // request on the bus right now

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int req_count     = 0;
   int enc_count     = 0;
   int dec_count     = 0;
   int oor_count     = 0;
   int rsp_count     = 0;
   int setting_count = 1;
   int quiet_cycles  = 0;

   // advance the shadow state by one request; returns 1 when a result is due
   function automatic bit apply_cipher_item(input cipher_req_type r,
                                            output cipher_rsp_type o);
      int k;
      int s;
      int n;
      o = '0;
      if (r.kind == rosc_pkg::REQ_LOAD) begin
         // a load with either field outside the symbol set is dropped
         if (int'(r.idx) < SYM && int'(r.val) < SYM) begin
            fwd_tab[r.idx] = r.val;
            rev_tab[r.val] = r.idx;
         end
         return 1'b0;
      end
      if (r.kind != rosc_pkg::REQ_ENCRYPT && r.kind != rosc_pkg::REQ_DECRYPT)
         return 1'b0;
      if (r.msg_first)
         run_off = field_type'(int'(cfg_start) % SYM);
      k = int'(run_off) % SYM;
      if (r.ch >= rosc_pkg::FIRST_CODE && r.ch <= LAST_CODE) begin
         s = int'(r.ch) - int'(rosc_pkg::FIRST_CODE);
         for (n = 0; n < int'(cfg_passes); n++) begin
            if (r.kind == rosc_pkg::REQ_DECRYPT)
               s = (int'(rev_tab[s]) + SYM - k) % SYM;
            else
               s = int'(fwd_tab[(s + k) % SYM]);
         end
         o.ch  = char_type'(s + int'(rosc_pkg::FIRST_CODE));
         o.oor = 1'b0;
      end else begin
         // non-printable characters pass through, flagged
         o.ch  = r.ch;
         o.oor = 1'b1;
      end
      run_off = field_type'((k + int'(cfg_step) % SYM) % SYM);
      return 1'b1;
   endfunction

   // driver: offers pending requests, predicts each one on its transfer
   always @(posedge clock) begin
      cipher_rsp_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            req_count++;
            if (apply_cipher_item(cur_req, want)) begin
               expected_chars.push_back(want);
               if (cur_req.kind == rosc_pkg::REQ_DECRYPT)
                  dec_count++;
               else
                  enc_count++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_tdata  <= {1'b0, cur_req.val, cur_req.idx, cur_req.ch, cur_req.msg_first};
               req_tuser  <= cur_req.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off that lets the block back up
   int hold_left = 0;
   int rsp_seen  = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
         end
      end
   end

   // monitor: every result transfer against the oldest prediction
   always @(posedge clock) begin
      cipher_rsp_type got;
      cipher_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch  = rsp_tdata;
         got.oor = rsp_tuser;
         rsp_count++;
         if (got.oor === 1'b1)
            oor_count++;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result char %h oor %b", $time, got.ch, got.oor);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected char %h oor %b, got char %h oor %b",
                        $time, want.ch, want.oor, got.ch, got.oor);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic cipher_req_type mk_req(input kind_type kind, input logic msg_first,
                                             input char_type ch, input field_type idx,
                                             input field_type val);
      cipher_req_type r;
      r.kind      = kind;
      r.msg_first = msg_first;
      r.ch        = ch;
      r.idx       = idx;
      r.val       = val;
      return r;
   endfunction

   // cipher request with random don't-care table fields
   function automatic cipher_req_type mk_char(input kind_type kind, input logic msg_first,
                                              input char_type ch);
      return mk_req(kind, msg_first, ch, field_type'($urandom_range(0, 127)),
                    field_type'($urandom_range(0, 127)));
   endfunction

   function automatic char_type rand_char();
      if ($urandom_range(0, 99) < 85)
         return char_type'($urandom_range(int'(rosc_pkg::FIRST_CODE), int'(LAST_CODE)));
      return char_type'($urandom_range(0, 255));
   endfunction

   // load a full random permutation so every entry of both tables is written
   task automatic queue_permutation();
      int perm [SYM];
      int i;
      int j;
      int tmp;
      for (i = 0; i < SYM; i++)
         perm[i] = i;
      for (i = SYM - 1; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (i = 0; i < SYM; i++)
         pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'($urandom_range(0, 1)),
                                       char_type'($urandom_range(0, 255)),
                                       field_type'(i), field_type'(perm[i])));
   endtask

   // mostly messages with random content, some single loads and some noise
   task automatic queue_traffic(input int count);
      int made;
      int pick;
      int len;
      int i;
      kind_type kind;
      made = 0;
      while (made < count) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 70) begin
            len  = int'($urandom_range(1, 10));
            kind = $urandom_range(0, 1) ? rosc_pkg::REQ_DECRYPT : rosc_pkg::REQ_ENCRYPT;
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 99) < 5)
                  pending_reqs.push_back(mk_req(kind_type'($urandom_range(0, 3)),
                                                1'($urandom_range(0, 1)),
                                                char_type'($urandom_range(0, 255)),
                                                field_type'($urandom_range(0, 127)),
                                                field_type'($urandom_range(0, 127))));
               if ($urandom_range(0, 99) < 10)
                  kind = (kind == rosc_pkg::REQ_ENCRYPT) ? rosc_pkg::REQ_DECRYPT
                                                         : rosc_pkg::REQ_ENCRYPT;
               pending_reqs.push_back(mk_char(kind, i == 0, rand_char()));
               made++;
            end
         end else if (pick < 80) begin
            pending_reqs.push_back(mk_char($urandom_range(0, 1) ? rosc_pkg::REQ_DECRYPT
                                                                : rosc_pkg::REQ_ENCRYPT,
                                           1'($urandom_range(0, 1)),
                                           char_type'($urandom_range(0, 255))));
            made++;
         end else if (pick < 90) begin
            // in-range load, usually breaks the permutation
            pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'($urandom_range(0, 1)),
                                          char_type'($urandom_range(0, 255)),
                                          field_type'($urandom_range(0, SYM - 1)),
                                          field_type'($urandom_range(0, SYM - 1))));
            made++;
         end else if (pick < 95) begin
            pending_reqs.push_back(mk_req(REQ_IGNORED, 1'($urandom_range(0, 1)),
                                          char_type'($urandom_range(0, 255)),
                                          field_type'($urandom_range(0, 127)),
                                          field_type'($urandom_range(0, 127))));
         end else begin
            // load with at least one field past the symbol set
            pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'($urandom_range(0, 1)),
                                          char_type'($urandom_range(0, 255)),
                                          field_type'($urandom_range(0, 127)),
                                          field_type'($urandom_range(SYM, 127))));
         end
      end
   endtask

   // block idle: nothing queued, nothing on the bus, every result in, tail settled
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_tvalid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rosc_pkg::CSR_IDX_W-1:0] idx, input wdata_type data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         rosc_pkg::CSR_START_OFFSET: cfg_start  = data[rosc_pkg::FIELD_W-1:0];
         rosc_pkg::CSR_OFFSET_STEP:  cfg_step   = data[rosc_pkg::FIELD_W-1:0];
         rosc_pkg::CSR_PASSES:       cfg_passes = data[rosc_pkg::PASS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input wdata_type start, input wdata_type step,
                            input wdata_type npass, input int send_pct,
                            input int recv_pct, input bit reload, input int count);
      wait_quiet();
      write_reg(rosc_pkg::CSR_START_OFFSET, start);
      write_reg(rosc_pkg::CSR_OFFSET_STEP, step);
      write_reg(rosc_pkg::CSR_PASSES, npass);
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (reload)
         queue_permutation();
      queue_traffic(count);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, receiver idles more often than not
      send_idle_pct = 38;
      recv_idle_pct = 51;

      // tables still unwritten: only requests that never read them
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b1, 8'd0));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_DECRYPT, 1'b0,
                                     rosc_pkg::FIRST_CODE - 8'd1));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, PAST_CODE));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_DECRYPT, 1'b1, 8'hff));
      pending_reqs.push_back(mk_req(REQ_IGNORED, 1'b1, 8'hff, 7'h7f, 7'h7f));
      pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'b1, 8'hff, field_type'(SYM), 7'd0));
      pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'b0, 8'h00, 7'd0, 7'h7f));
      pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'b1, 8'h55, 7'h7f, 7'h7f));
      queue_permutation();

      // edges of the printable range, both directions
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b1, rosc_pkg::FIRST_CODE));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, LAST_CODE));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_DECRYPT, 1'b1, rosc_pkg::FIRST_CODE));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_DECRYPT, 1'b0, LAST_CODE));
      // out of range in the middle of a message still moves the offset
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, 8'h80));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, 8'd65));
      // an ignored kind inside a message leaves the offset alone
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b1, 8'd72));
      pending_reqs.push_back(mk_req(REQ_IGNORED, 1'b1, 8'd72, 7'd1, 7'd2));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, 8'd105));
      // two entries pointing at one value: tables no longer a permutation
      pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'b1, 8'd0, 7'd3, 7'd5));
      pending_reqs.push_back(mk_req(rosc_pkg::REQ_LOAD, 1'b0, 8'd0, 7'd4, 7'd5));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_DECRYPT, 1'b0, 8'd37));
      pending_reqs.push_back(mk_char(rosc_pkg::REQ_ENCRYPT, 1'b0, 8'd35));
      queue_traffic(250);

      // largest offsets in range and the most passes
      run_phase(8'd94, 8'd94, 8'd255, 38, 51, 1'b0, 60);
      // zero passes: characters echo back
      run_phase(8'd0, 8'd0, 8'd0, 51, 38, 1'b0, 200);
      // offsets beyond the symbol count wrap
      run_phase(8'd127, 8'd127, 8'd1, 51, 38, 1'b0, 200);
      run_phase(wdata_type'($urandom_range(0, 94)), wdata_type'($urandom_range(0, 94)),
                wdata_type'($urandom_range(1, 40)), 51, 38, 1'b1, 200);
      run_phase(wdata_type'($urandom_range(0, 127)), wdata_type'($urandom_range(0, 127)),
                wdata_type'($urandom_range(1, 20)), 0, 0, 1'b0, 150);
      run_phase(8'd1, 8'd95, 8'd2, 0, 0, 1'b1, 150);
      wait_quiet();

      $display("%0d requests, %0d results (%0d encrypt, %0d decrypt, %0d out of range)",
               req_count, rsp_count, enc_count, dec_count, oor_count);
      $display("%0d register settings, three idle patterns, one long result hold-off, %0d errors",
               setting_count, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
